// ----- design/ssd_pkg.sv -----
// Package for the segment distance pipeline: field widths, request and
// result payload types, orientation flags. No dependencies.
package ssd_pkg;

  localparam int COORD_W = 16;
  localparam int DIST_W  = 25;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int SUM_W   = PROD_W + 1;
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t a_start_x;
    coord_t a_start_y;
    coord_t a_end_x;
    coord_t a_end_y;
    coord_t b_start_x;
    coord_t b_start_y;
    coord_t b_end_x;
    coord_t b_end_y;
  } in_req_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              segments_touch;
  } out_res_t;

  // zero: point on the segment; neg: clockwise or beyond the far end
  typedef struct packed {
    logic zero;
    logic neg;
  } ori_t;

endpackage

// ----- design/ssd_geom.sv -----
// One segment-to-point lane: differences, products, sums, orientation and
// the squared-distance numerator and denominator. Depends on ssd_pkg.
module ssd_geom #(
  parameter int FRAC_BITS = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  ssd_pkg::coord_t seg_ax,
  input  ssd_pkg::coord_t seg_ay,
  input  ssd_pkg::coord_t seg_bx,
  input  ssd_pkg::coord_t seg_by,
  input  ssd_pkg::coord_t pt_x,
  input  ssd_pkg::coord_t pt_y,
  output logic            out_valid,
  output ssd_pkg::ori_t   out_ori,
  output logic [2*(ssd_pkg::PROD_W+FRAC_BITS+1)-1:0] out_num,
  output logic [ssd_pkg::SUM_W-1:0] out_den
);
  import ssd_pkg::*;

  localparam int NUM_W = 2 * (PROD_W + FRAC_BITS + 1);
  localparam int SHF   = 2 * FRAC_BITS + 2;

  logic [4:0] v_r;

  logic signed [DIFF_W-1:0] dx_r, dy_r, px_r, py_r, qx_r, qy_r;
  logic signed [PROD_W-1:0] dxpx_r, dypy_r, dxqx_r, dyqy_r, dxpy_r, dypx_r;
  logic signed [PROD_W-1:0] dxdx_r, dydy_r, pxpx_r, pypy_r, qxqx_r, qyqy_r;
  logic signed [SUM_W-1:0]  cross_r, dot1_r, dotq_r, len2_r, sp_r, sq_r;
  logic                     pt_mode_r;
  logic [SUM_W-1:0]         s_r, l_r;
  logic [PROD_W-1:0]        cabs_r;
  ori_t                     ori4_r, ori5_r;
  logic [NUM_W-1:0]         num_r;
  logic [SUM_W-1:0]         den_r;

  logic signed [SUM_W-1:0]  cneg;
  logic                     pa, pb;
  ori_t                     ori_nxt;
  logic [2*PROD_W-1:0]      csq;

  always_comb begin
    cneg = -cross_r;
    pa   = (dot1_r <= 0);
    pb   = (dotq_r >= 0);
    ori_nxt.zero = (cross_r == 0) && (dot1_r >= 0) && (len2_r >= sp_r);
    ori_nxt.neg  = (cross_r < 0) || ((cross_r == 0) && (dot1_r >= 0) && (len2_r < sp_r));
    csq = cabs_r * cabs_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[3:0], in_valid};
    end
    dx_r <= DIFF_W'(seg_bx) - DIFF_W'(seg_ax);
    dy_r <= DIFF_W'(seg_by) - DIFF_W'(seg_ay);
    px_r <= DIFF_W'(pt_x) - DIFF_W'(seg_ax);
    py_r <= DIFF_W'(pt_y) - DIFF_W'(seg_ay);
    qx_r <= DIFF_W'(pt_x) - DIFF_W'(seg_bx);
    qy_r <= DIFF_W'(pt_y) - DIFF_W'(seg_by);

    dxpx_r <= dx_r * px_r;
    dypy_r <= dy_r * py_r;
    dxqx_r <= dx_r * qx_r;
    dyqy_r <= dy_r * qy_r;
    dxpy_r <= dx_r * py_r;
    dypx_r <= dy_r * px_r;
    dxdx_r <= dx_r * dx_r;
    dydy_r <= dy_r * dy_r;
    pxpx_r <= px_r * px_r;
    pypy_r <= py_r * py_r;
    qxqx_r <= qx_r * qx_r;
    qyqy_r <= qy_r * qy_r;

    cross_r <= SUM_W'(dxpy_r) - SUM_W'(dypx_r);
    dot1_r  <= SUM_W'(dxpx_r) + SUM_W'(dypy_r);
    dotq_r  <= SUM_W'(dxqx_r) + SUM_W'(dyqy_r);
    len2_r  <= SUM_W'(dxdx_r) + SUM_W'(dydy_r);
    sp_r    <= SUM_W'(pxpx_r) + SUM_W'(pypy_r);
    sq_r    <= SUM_W'(qxqx_r) + SUM_W'(qyqy_r);

    pt_mode_r <= pa || pb;
    s_r       <= pa ? sp_r : sq_r;
    l_r       <= len2_r;
    cabs_r    <= (cross_r < 0) ? cneg[PROD_W-1:0] : cross_r[PROD_W-1:0];
    ori4_r    <= ori_nxt;

    num_r  <= pt_mode_r ? (NUM_W'(s_r) << SHF) : (NUM_W'(csq) << SHF);
    den_r  <= pt_mode_r ? SUM_W'(1) : l_r;
    ori5_r <= ori4_r;
  end

  assign out_valid = v_r[4];
  assign out_ori   = ori5_r;
  assign out_num   = num_r;
  assign out_den   = den_r;

endmodule

// ----- design/ssd_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
// Depends on nothing beyond its parameters.
module ssd_div #(
  parameter int NUM_W = 88,
  parameter int DEN_W = 35,
  parameter int QUO_W = 53
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] in_num,
  input  logic [DEN_W-1:0] in_den,
  output logic             out_valid,
  output logic [QUO_W-1:0] out_quo
);

  logic [QUO_W-1:0] v_r;
  logic [DEN_W-1:0] rem_r [QUO_W];
  logic [QUO_W-1:0] sh_r  [QUO_W];
  logic [DEN_W-1:0] den_r [QUO_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[QUO_W-2:0], in_valid};
    end
  end

  for (genvar k = 0; k < QUO_W; k++) begin : g_stg
    logic [DEN_W-1:0] p_rem, p_den;
    logic [QUO_W-1:0] p_sh;
    logic [DEN_W:0]   t;
    logic             ge;
    if (k == 0) begin : g_first
      assign p_rem = DEN_W'(in_num[NUM_W-1:QUO_W]);
      assign p_sh  = in_num[QUO_W-1:0];
      assign p_den = in_den;
    end else begin : g_next
      assign p_rem = rem_r[k-1];
      assign p_sh  = sh_r[k-1];
      assign p_den = den_r[k-1];
    end
    assign t  = {p_rem, p_sh[QUO_W-1]};
    assign ge = (t >= {1'b0, p_den});
    always_ff @(posedge clk) begin
      rem_r[k] <= ge ? DEN_W'(t - {1'b0, p_den}) : t[DEN_W-1:0];
      sh_r[k]  <= {p_sh[QUO_W-2:0], ge};
      den_r[k] <= p_den;
    end
  end

  assign out_valid = v_r[QUO_W-1];
  assign out_quo   = sh_r[QUO_W-1];

endmodule

// ----- design/ssd_isqrt.sv -----
// Pipelined integer square root, one root bit per stage.
// Depends on nothing beyond its parameters.
module ssd_isqrt #(
  parameter int IN_W = 53,
  parameter int RT_W = 27
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [IN_W-1:0] in_x,
  output logic            out_valid,
  output logic [RT_W-1:0] out_root
);

  localparam int X_W = 2 * RT_W;

  logic [RT_W-1:0] v_r;
  logic [RT_W+1:0] rem_r  [RT_W];
  logic [RT_W-1:0] root_r [RT_W];
  logic [X_W-1:0]  x_r    [RT_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[RT_W-2:0], in_valid};
    end
  end

  for (genvar k = 0; k < RT_W; k++) begin : g_stg
    logic [RT_W+1:0] p_rem, t, trial;
    logic [RT_W-1:0] p_root;
    logic [X_W-1:0]  p_x;
    logic            ge;
    if (k == 0) begin : g_first
      assign p_rem  = '0;
      assign p_root = '0;
      assign p_x    = X_W'(in_x);
    end else begin : g_next
      assign p_rem  = rem_r[k-1];
      assign p_root = root_r[k-1];
      assign p_x    = x_r[k-1];
    end
    assign t     = {p_rem[RT_W-1:0], p_x[X_W-1:X_W-2]};
    assign trial = {p_root, 2'b01};
    assign ge    = (t >= trial);
    always_ff @(posedge clk) begin
      rem_r[k]  <= ge ? (t - trial) : t;
      root_r[k] <= {p_root[RT_W-2:0], ge};
      x_r[k]    <= {p_x[X_W-3:0], 2'b00};
    end
  end

  assign out_valid = v_r[RT_W-1];
  assign out_root  = root_r[RT_W-1];

endmodule

// ----- design/segment_segment_distance_top.sv -----
// Top level of the segment distance pipeline: four geometry lanes,
// dividers, minimum, square root, rounding. Depends on ssd_pkg and all ssd_ modules.
//
//  channel  ports                     handshake
//  request  start, busy, in_data      taken when start and not busy
//  result   out_valid, out_data       one-cycle strobe, no backpressure
//
// One request per cycle; busy stays low. The pipeline has five geometry
// stages, one divider stage per quotient bit, two minimum stages, one root
// stage per root bit and one rounding stage. Reset clears the valid bits only.
module segment_segment_distance_top #(
  parameter int FRAC_BITS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  ssd_pkg::in_req_t  in_data,
  output logic              out_valid,
  output ssd_pkg::out_res_t out_data
);
  import ssd_pkg::*;

  localparam int NUM_W = 2 * (PROD_W + FRAC_BITS + 1);
  localparam int QUO_W = SUM_W + 2 * FRAC_BITS + 2;
  localparam int RT_W  = (QUO_W + 1) / 2;
  localparam int TD    = QUO_W + 2 + RT_W;
  localparam int LAT   = 5 + TD + 1;
  localparam int RS_W  = (RT_W > DIST_W + 1 ? RT_W : DIST_W + 1) + 1;

  logic             g_v   [4];
  ori_t             g_ori [4];
  logic [NUM_W-1:0] g_num [4];
  logic [SUM_W-1:0] g_den [4];
  logic             d_v   [4];
  logic [QUO_W-1:0] d_q   [4];

  coord_t sax [4], say [4], sbx [4], sby [4], ptx [4], pty [4];

  always_comb begin
    sax[0] = in_data.a_start_x; say[0] = in_data.a_start_y;
    sbx[0] = in_data.a_end_x;   sby[0] = in_data.a_end_y;
    ptx[0] = in_data.b_start_x; pty[0] = in_data.b_start_y;
    sax[1] = in_data.a_start_x; say[1] = in_data.a_start_y;
    sbx[1] = in_data.a_end_x;   sby[1] = in_data.a_end_y;
    ptx[1] = in_data.b_end_x;   pty[1] = in_data.b_end_y;
    sax[2] = in_data.b_start_x; say[2] = in_data.b_start_y;
    sbx[2] = in_data.b_end_x;   sby[2] = in_data.b_end_y;
    ptx[2] = in_data.a_start_x; pty[2] = in_data.a_start_y;
    sax[3] = in_data.b_start_x; say[3] = in_data.b_start_y;
    sbx[3] = in_data.b_end_x;   sby[3] = in_data.b_end_y;
    ptx[3] = in_data.a_end_x;   pty[3] = in_data.a_end_y;
  end

  logic acc;
  assign busy = 1'b0;
  assign acc  = start && !busy;

  for (genvar i = 0; i < 4; i++) begin : g_lane
    ssd_geom #(.FRAC_BITS(FRAC_BITS)) u_geom (
      .clk(clk), .rst_n(rst_n), .in_valid(acc),
      .seg_ax(sax[i]), .seg_ay(say[i]), .seg_bx(sbx[i]), .seg_by(sby[i]),
      .pt_x(ptx[i]), .pt_y(pty[i]),
      .out_valid(g_v[i]), .out_ori(g_ori[i]), .out_num(g_num[i]), .out_den(g_den[i])
    );
    ssd_div #(.NUM_W(NUM_W), .DEN_W(SUM_W), .QUO_W(QUO_W)) u_div (
      .clk(clk), .rst_n(rst_n), .in_valid(g_v[i]),
      .in_num(g_num[i]), .in_den(g_den[i]),
      .out_valid(d_v[i]), .out_quo(d_q[i])
    );
  end

  // touch flag: both orientation products not positive
  logic touch;
  assign touch = (g_ori[0].zero || g_ori[1].zero || (g_ori[0].neg ^ g_ori[1].neg)) &&
                 (g_ori[2].zero || g_ori[3].zero || (g_ori[2].neg ^ g_ori[3].neg));

  logic tch_r [TD];
  always_ff @(posedge clk) begin
    tch_r[0] <= touch;
    for (int k = 1; k < TD; k++) begin
      tch_r[k] <= tch_r[k-1];
    end
  end

  logic [1:0]       mn_v_r;
  logic [QUO_W-1:0] m01_r, m23_r, mn_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mn_v_r <= '0;
    end else begin
      mn_v_r <= {mn_v_r[0], d_v[0]};
    end
    m01_r <= (d_q[1] < d_q[0]) ? d_q[1] : d_q[0];
    m23_r <= (d_q[3] < d_q[2]) ? d_q[3] : d_q[2];
    mn_r  <= (m23_r < m01_r) ? m23_r : m01_r;
  end

  logic            rt_v;
  logic [RT_W-1:0] rt;
  ssd_isqrt #(.IN_W(QUO_W), .RT_W(RT_W)) u_isqrt (
    .clk(clk), .rst_n(rst_n), .in_valid(mn_v_r[1]), .in_x(mn_r),
    .out_valid(rt_v), .out_root(rt)
  );

  logic [RS_W-1:0]   rnd;
  logic [DIST_W-1:0] dist_nxt;
  always_comb begin
    rnd      = RS_W'(rt) + RS_W'(1);
    dist_nxt = (rnd[RS_W-1:1] > (RS_W-1)'(DIST_MAX)) ? DIST_MAX : rnd[DIST_W:1];
  end

  logic     ov_r;
  out_res_t od_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= rt_v;
    end
    od_r.segments_touch <= tch_r[TD-1];
    od_r.distance       <= tch_r[TD-1] ? '0 : dist_nxt;
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;

`ifndef ASSERT_OFF
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    acc |-> ##LAT out_valid) else $error("request lost in pipeline");
  a_touch_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.segments_touch |-> out_data.distance == '0)
    else $error("touching segments with nonzero distance");
  a_root_out: assert property (@(posedge clk) disable iff (!rst_n)
    rt_v |=> out_valid) else $error("root result dropped");
  a_lanes: assert property (@(posedge clk) disable iff (!rst_n)
    d_v[0] == d_v[3] && d_v[1] == d_v[2]) else $error("divider lanes out of step");
`endif

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// Testbench for segment_segment_distance_top: directed and random segment pairs,
// checked against a local bit-exact predictor. Depends on ssd_pkg and the design.
module tb;
  import ssd_pkg::*;

  localparam int LAT = 88;
  localparam int LIMIT = 200000;
  localparam int N_RAND = 1750;

  class dist_scoreboard;
    out_res_t pending[$];
    int errors;

    static function logic [31:0] root_floor(logic [127:0] l, logic [127:0] n);
      logic [31:0] r;
      logic [127:0] t;
      r = '0;
      if (l == 0) return '0;
      for (int b = 31; b >= 0; b--) begin
        t = {96'b0, r | (32'd1 << b)};
        if (t * t * l <= n) r = r | (32'd1 << b);
      end
      return r;
    endfunction

    static function logic [DIST_W-1:0] round_up(logic [31:0] twice);
      logic [32:0] q;
      q = ({1'b0, twice} + 33'd1) >> 1;
      return (q > DIST_MAX) ? DIST_MAX : q[DIST_W-1:0];
    endfunction

    static function logic [DIST_W-1:0] point_dist(longint dx, longint dy);
      logic [127:0] n;
      n = 128'(dx * dx + dy * dy) << 18;
      return round_up(root_floor(128'd1, n));
    endfunction

    static function logic [DIST_W-1:0] seg_pt(longint ax, longint ay,
        longint bx, longint by, longint px, longint py);
      longint dx, dy, qx, qy, c, len2;
      logic [127:0] m;
      dx = bx - ax; dy = by - ay; qx = px - ax; qy = py - ay;
      if (dx * qx + dy * qy <= 0) return point_dist(qx, qy);
      if (-dx * (px - bx) - dy * (py - by) <= 0) return point_dist(px - bx, py - by);
      c = dx * qy - dy * qx;
      if (c < 0) c = -c;
      len2 = dx * dx + dy * dy;
      m = 128'(c) << 9;
      return round_up(root_floor(128'(len2), m * m));
    endfunction

    static function int orient(longint ax, longint ay, longint bx, longint by,
        longint cx, longint cy);
      longint ux, uy, vx, vy, cr;
      ux = bx - ax; uy = by - ay; vx = cx - ax; vy = cy - ay;
      cr = ux * vy - uy * vx;
      if (cr > 0) return 1;
      if (cr < 0) return -1;
      if (ux * vx + uy * vy < 0) return 2;
      if (ux * ux + uy * uy < vx * vx + vy * vy) return -2;
      return 0;
    endfunction

    static function out_res_t predict(in_req_t r);
      longint a1x, a1y, a2x, a2y, b1x, b1y, b2x, b2y;
      logic [DIST_W-1:0] d, t;
      out_res_t o;
      a1x = r.a_start_x; a1y = r.a_start_y; a2x = r.a_end_x; a2y = r.a_end_y;
      b1x = r.b_start_x; b1y = r.b_start_y; b2x = r.b_end_x; b2y = r.b_end_y;
      o.segments_touch =
        orient(a1x, a1y, a2x, a2y, b1x, b1y) * orient(a1x, a1y, a2x, a2y, b2x, b2y) <= 0 &&
        orient(b1x, b1y, b2x, b2y, a1x, a1y) * orient(b1x, b1y, b2x, b2y, a2x, a2y) <= 0;
      if (o.segments_touch) begin
        d = '0;
      end else begin
        d = seg_pt(a1x, a1y, a2x, a2y, b1x, b1y);
        t = seg_pt(a1x, a1y, a2x, a2y, b2x, b2y); if (t < d) d = t;
        t = seg_pt(b1x, b1y, b2x, b2y, a1x, a1y); if (t < d) d = t;
        t = seg_pt(b1x, b1y, b2x, b2y, a2x, a2y); if (t < d) d = t;
      end
      o.distance = d;
      return o;
    endfunction

    function void note(in_req_t r);
      pending = {pending, predict(r)};
    endfunction

    function void check(out_res_t got);
      out_res_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result distance=%0d touch=%0b", $time,
                 got.distance, got.segments_touch);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.distance !== exp_r.distance) begin
        $display("%0t: distance expected %0d actual %0d", $time, exp_r.distance, got.distance);
        errors++;
      end
      if (got.segments_touch !== exp_r.segments_touch) begin
        $display("%0t: segments_touch expected %0b actual %0b", $time,
                 exp_r.segments_touch, got.segments_touch);
        errors++;
      end
    endfunction
  endclass

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  in_req_t  in_data;
  logic     out_valid;
  out_res_t out_data;

  dist_scoreboard sb;
  int accepted;
  int sent;
  int cycles;

  segment_segment_distance_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("FAIL");
      $finish;
    end
    if (rst_n && start && !busy) begin
      sb.note(in_data);
      accepted++;
    end
    if (rst_n && out_valid) sb.check(out_data);
  end

  function automatic in_req_t mk(int ax, int ay, int bx, int by,
                                 int cx, int cy, int dx, int dy);
    in_req_t r;
    r.a_start_x = COORD_W'(ax); r.a_start_y = COORD_W'(ay);
    r.a_end_x   = COORD_W'(bx); r.a_end_y   = COORD_W'(by);
    r.b_start_x = COORD_W'(cx); r.b_start_y = COORD_W'(cy);
    r.b_end_x   = COORD_W'(dx); r.b_end_y   = COORD_W'(dy);
    return r;
  endfunction

  function automatic int pick(int mode);
    int e;
    case (mode)
      0: return int'($signed($urandom_range(65535, 0) - 32768));
      1: return $urandom_range(16, 0) - 8;
      2: return $urandom_range(2000, 0) - 1000;
      default: begin
        e = $urandom_range(3, 0);
        return (e == 0) ? -32768 : (e == 1) ? 32767 : (e == 2) ? 0 : -1;
      end
    endcase
  endfunction

  function automatic in_req_t rand_req();
    int px, py, ux, uy, k[4], mode, v[8];
    mode = $urandom_range(9, 0);
    if (mode < 3) begin
      // collinear points on a common line
      px = pick(2); py = pick(2);
      ux = $urandom_range(40, 0) - 20; uy = $urandom_range(40, 0) - 20;
      foreach (k[i]) k[i] = $urandom_range(20, 0) - 10;
      return mk(px + k[0] * ux, py + k[0] * uy, px + k[1] * ux, py + k[1] * uy,
                px + k[2] * ux, py + k[2] * uy, px + k[3] * ux, py + k[3] * uy);
    end
    foreach (v[i]) v[i] = pick(mode < 5 ? 0 : mode < 7 ? 1 : mode < 9 ? 2 : 3);
    if ($urandom_range(5, 0) == 0) begin
      v[4 + 2 * $urandom_range(1, 0)] = v[0];
      v[5 + 2 * $urandom_range(1, 0) - 0] = v[1];
    end
    if ($urandom_range(9, 0) == 0) begin
      v[2] = v[0]; v[3] = v[1];
    end
    return mk(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]);
  endfunction

  task automatic send_req(in_req_t r, int idle_pct);
    while ($urandom_range(99, 0) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_data <= r;
    sent++;
    do @(negedge clk); while (accepted != sent);
  endtask

  initial begin
    in_req_t dir[$];
    int idle;
    sb = new();
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    dir = {dir, mk(0, 0, 10, 10, 0, 10, 10, 0)};
    dir = {dir, mk(0, 0, 10, 0, 10, 0, 20, 5)};
    dir = {dir, mk(0, 0, 10, 0, 5, 0, 20, 0)};
    dir = {dir, mk(0, 0, 10, 0, 11, 0, 20, 0)};
    dir = {dir, mk(0, 0, 10, 0, 0, 3, 10, 3)};
    dir = {dir, mk(0, 0, 10, 0, 5, 1, 5, 7)};
    dir = {dir, mk(3, 4, 3, 4, 0, 0, 0, 0)};
    dir = {dir, mk(3, 4, 3, 4, 3, 4, 3, 4)};
    dir = {dir, mk(5, 5, 5, 5, 0, 0, 10, 10)};
    dir = {dir, mk(5, 6, 5, 6, 0, 0, 10, 10)};
    dir = {dir, mk(-32768, -32768, -32768, -32768, 32767, 32767, 32767, 32767)};
    dir = {dir, mk(-32768, -32768, 32767, -32768, -32768, 32767, 32767, 32767)};
    dir = {dir, mk(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768)};
    dir = {dir, mk(-32768, 32767, -32768, 32767, 32767, -32768, 32767, -32768)};
    dir = {dir, mk(-1, -1, -1, -1, -1, -1, -1, -1)};
    dir = {dir, mk(0, 0, 1, 2, 0, 1, 1, 3)};
    dir = {dir, mk(0, 0, 3, 1, 1, 5, 2, 7)};
    dir = {dir, mk(32767, 0, -32768, 1, 0, 32767, 1, -32768)};
    dir = {dir, mk(0, 0, 0, 10, 0, 10, 0, 20)};
    dir = {dir, mk(0, 0, 1, 1, 2, 2, 3, 3)};
    foreach (dir[i]) send_req(dir[i], 0);

    for (int i = 0; i < N_RAND; i++) begin
      idle = (i < N_RAND / 3) ? 30 : (i < 2 * N_RAND / 3) ? 77 : 0;
      send_req(rand_req(), idle);
    end
    start <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LAT + 10) @(posedge clk);
    if (sb.pending.size() != 0) begin
      $display("%0t: %0d results missing", $time, sb.pending.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

// ----- files.f -----
design/ssd_pkg.sv
design/ssd_geom.sv
design/ssd_div.sv
design/ssd_isqrt.sv
design/segment_segment_distance_top.sv
verif/tb.sv
